// ===== rtl/bfac_pkg.sv =====
// bfac_pkg: shared constants, codes and widths for the bloom filter add/check block
// no dependencies; used by bfac_if.sv and bloom_filter_add_check.sv
package bfac_pkg;

  localparam int FILTER_BITS_DEF = 65536;
  localparam int MAX_PROBES_DEF  = 16;
  localparam int KEY_BYTES_DEF   = 8;

  localparam int TYPE_W    = 2;
  localparam int KEY_W     = 64;
  localparam int KLEN_W    = 4;
  localparam int COUNT_W   = 32;
  localparam int BCOUNT_W  = 17;
  localparam int HCOUNT_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 17;

  localparam logic [31:0] HASH_SEED = 32'h9747_b28c;
  localparam logic [31:0] MIX_MUL   = 32'h5bd1_e995;

  localparam logic [BCOUNT_W-1:0] BIT_COUNT_RST  = 17'd65536;
  localparam logic [HCOUNT_W-1:0] HASH_COUNT_RST = 5'd7;

  localparam logic [TYPE_W-1:0] REQ_CHECK = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_ADD   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 1'd1;

  typedef logic [TYPE_W-1:0]  req_type_t;
  typedef logic [KEY_W-1:0]   key_value_t;
  typedef logic [KLEN_W-1:0]  key_length_t;
  typedef logic [COUNT_W-1:0] added_total_t;

endpackage

// ===== rtl/bfac_if.sv =====
// bfac_req_if / bfac_rsp_if: valid/ready channels for requests and results
// depends on bfac_pkg
interface bfac_req_if;
  import bfac_pkg::*;
  logic        valid;
  logic        ready;
  req_type_t   req_type;
  key_value_t  key_value;
  key_length_t key_length;
  modport source (output valid, req_type, key_value, key_length, input ready);
  modport sink (input valid, req_type, key_value, key_length, output ready);
endinterface

interface bfac_rsp_if;
  import bfac_pkg::*;
  logic         valid;
  logic         ready;
  logic         present;
  added_total_t added_total;
  modport source (output valid, present, added_total, input ready);
  modport sink (input valid, present, added_total, output ready);
endinterface

// ===== rtl/bloom_filter_add_check.sv =====
// Bloom filter add/check over two MurmurHash2 hashes with double-hashed probes. One request
// is in work at a time; the result is held until taken, then the next request is accepted.
// A request costs two hash passes (steps K1, K2 and H per 4-byte block, TAIL for a tail, FIN1
// and FIN2 to finish, on the one shared multiplier), then per probe a bit-serial modulo, a
// filter read and a use step. Check stops at the first clear bit; add runs a second probe
// pass for the writes. Clear, and reset, sweep the filter memory one 32-bit row a cycle,
// with ready low meanwhile.
// depends on bfac_pkg and bfac_if
module bloom_filter_add_check #(
  parameter int FILTER_BITS = bfac_pkg::FILTER_BITS_DEF,
  parameter int MAX_PROBES  = bfac_pkg::MAX_PROBES_DEF,
  parameter int KEY_BYTES   = bfac_pkg::KEY_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bfac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfac_pkg::CFG_DAT_W-1:0] cfg_data,
  bfac_req_if.sink                       in_ch,
  bfac_rsp_if.source                     out_ch
);
  import bfac_pkg::*;

  localparam int WORD_COUNT = (FILTER_BITS + 31) / 32;
  localparam int AW = $clog2(WORD_COUNT);
  localparam int MW = $clog2(FILTER_BITS + 1);
  localparam int PW = $clog2(MAX_PROBES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_HASH = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_USE  = 3'd5;
  localparam logic [2:0] ST_RESP = 3'd6;

  localparam logic [2:0] HS_K1   = 3'd0;
  localparam logic [2:0] HS_K2   = 3'd1;
  localparam logic [2:0] HS_H    = 3'd2;
  localparam logic [2:0] HS_TAIL = 3'd3;
  localparam logic [2:0] HS_FIN1 = 3'd4;
  localparam logic [2:0] HS_FIN2 = 3'd5;

  logic [31:0] mem [WORD_COUNT];

  logic [2:0]          state_r, state_nxt;
  logic [2:0]          hs_r, hs_nxt;
  logic [BCOUNT_W-1:0] bit_count_r;
  logic [HCOUNT_W-1:0] hash_count_r;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic                clr_req_r, clr_req_nxt;
  logic [COUNT_W-1:0]  add_cnt_r, add_cnt_nxt;
  logic                present_r, present_nxt;
  logic                is_add_r, is_add_nxt;
  logic                phase_r, phase_nxt;
  logic                pass_r, pass_nxt;
  logic                blk_r, blk_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [KLEN_W-1:0]   len_r, len_nxt;
  logic [MW-1:0]       mod_r, mod_nxt;
  logic [PW-1:0]       probes_r, probes_nxt;
  logic [PW-1:0]       idx_r, idx_nxt;
  logic [31:0]         h_r, h_nxt, k_r, k_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [31:0]         p_r, p_nxt, dv_r, dv_nxt;
  logic [MW-1:0]       rem_r, rem_nxt;
  logic [4:0]          step_r, step_nxt;
  logic [31:0]         rd_r;

  logic [31:0] mul_in, mul_out, word, tail, tail_mask, hfin, mod32, pr32, len32;
  logic [MW:0] div_t;
  logic [2:0]  hs_first;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, rd_addr;
  logic [31:0] mem_wdata;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = (state_r == ST_RESP);
  assign out_ch.present     = present_r;
  assign out_ch.added_total = add_cnt_r;

  assign word    = key_r[{blk_r, 5'b0} +: 32];
  assign tail    = key_r[{len_r[2], 5'b0} +: 32] & tail_mask;
  assign mul_out = mul_in * MIX_MUL;
  assign hfin    = h_r ^ (h_r >> 15);
  assign div_t   = {rem_r, dv_r[31]};
  assign rd_addr = rem_r[AW+4:5];
  assign hs_first = (len_r[3:2] != 2'd0) ? HS_K1 : (len_r[1:0] != 2'd0) ? HS_TAIL : HS_FIN1;

  always_comb begin
    unique case (len_r[1:0])
      2'd1: tail_mask = 32'h0000_00ff;
      2'd2: tail_mask = 32'h0000_ffff;
      2'd3: tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0;
    endcase
    unique case (hs_r)
      HS_K1: mul_in = word;
      HS_K2: mul_in = k_r ^ (k_r >> 24);
      HS_H: mul_in = h_r;
      HS_TAIL: mul_in = h_r ^ tail;
      default: mul_in = h_r ^ (h_r >> 13);
    endcase
    mod32 = {15'b0, bit_count_r};
    if (mod32 == 32'd0) mod32 = 32'd1;
    else if (mod32 > 32'(FILTER_BITS)) mod32 = 32'(FILTER_BITS);
    pr32 = {27'b0, hash_count_r};
    if (pr32 > 32'(MAX_PROBES)) pr32 = 32'(MAX_PROBES);
    len32 = {28'b0, in_ch.key_length};
    if (len32 > 32'(KEY_BYTES)) len32 = 32'(KEY_BYTES);
  end

  always_comb begin
    state_nxt = state_r; hs_nxt = hs_r; clr_addr_nxt = clr_addr_r; clr_req_nxt = clr_req_r;
    add_cnt_nxt = add_cnt_r; present_nxt = present_r; is_add_nxt = is_add_r;
    phase_nxt = phase_r; pass_nxt = pass_r; blk_nxt = blk_r; key_nxt = key_r; len_nxt = len_r;
    mod_nxt = mod_r; probes_nxt = probes_r; idx_nxt = idx_r; h_nxt = h_r; k_nxt = k_r;
    a_nxt = a_r; b_nxt = b_r; p_nxt = p_r; dv_nxt = dv_r; rem_nxt = rem_r; step_nxt = step_r;
    mem_we = 1'b0; mem_waddr = rd_addr; mem_wdata = rd_r | (32'd1 << rem_r[4:0]);
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          key_nxt = in_ch.key_value;
          len_nxt = len32[KLEN_W-1:0];
          mod_nxt = mod32[MW-1:0];
          probes_nxt = pr32[PW-1:0];
          is_add_nxt = (in_ch.req_type == REQ_ADD);
          present_nxt = 1'b0;
          if (in_ch.req_type == REQ_CLEAR) begin
            state_nxt = ST_CLR; clr_req_nxt = 1'b1; clr_addr_nxt = '0;
          end else if (in_ch.req_type == REQ_CHECK || in_ch.req_type == REQ_ADD) begin
            state_nxt = ST_HASH; pass_nxt = 1'b0; blk_nxt = 1'b0;
            h_nxt = HASH_SEED ^ {28'b0, len32[KLEN_W-1:0]};
            hs_nxt = (len32[3:2] != 2'd0) ? HS_K1 : (len32[1:0] != 2'd0) ? HS_TAIL : HS_FIN1;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_CLR: begin
        mem_we = 1'b1; mem_waddr = clr_addr_r; mem_wdata = '0;
        if (clr_addr_r == AW'(WORD_COUNT - 1)) begin
          state_nxt = clr_req_r ? ST_RESP : ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_HASH: begin
        unique case (hs_r)
          HS_K1: begin k_nxt = mul_out; hs_nxt = HS_K2; end
          HS_K2: begin k_nxt = mul_out; hs_nxt = HS_H; end
          HS_H: begin
            h_nxt = mul_out ^ k_r;
            blk_nxt = 1'b1;
            if (!blk_r && len_r[3:2] == 2'd2) hs_nxt = HS_K1;
            else if (len_r[1:0] != 2'd0) hs_nxt = HS_TAIL;
            else hs_nxt = HS_FIN1;
          end
          HS_TAIL: begin h_nxt = mul_out; hs_nxt = HS_FIN1; end
          HS_FIN1: begin h_nxt = mul_out; hs_nxt = HS_FIN2; end
          default: begin
            if (!pass_r) begin
              a_nxt = hfin; h_nxt = hfin ^ {28'b0, len_r};
              pass_nxt = 1'b1; blk_nxt = 1'b0; hs_nxt = hs_first;
            end else begin
              b_nxt = hfin; p_nxt = a_r; idx_nxt = '0; phase_nxt = 1'b0;
              present_nxt = 1'b1;
              if (probes_r == '0) begin
                if (is_add_r && add_cnt_r != '1) add_cnt_nxt = add_cnt_r + 1'b1;
                state_nxt = ST_RESP;
              end else begin
                state_nxt = ST_DIV; dv_nxt = a_r; rem_nxt = '0; step_nxt = '0;
              end
            end
          end
        endcase
      end
      ST_DIV: begin
        dv_nxt = {dv_r[30:0], 1'b0};
        rem_nxt = (div_t >= {1'b0, mod_r}) ? MW'(div_t - {1'b0, mod_r}) : div_t[MW-1:0];
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd31) state_nxt = ST_RD;
      end
      ST_RD: state_nxt = ST_USE;
      default: begin
        if (state_r == ST_USE) begin
          if (phase_r) mem_we = 1'b1;
          if (!phase_r && !rd_r[rem_r[4:0]]) begin
            present_nxt = 1'b0;
          end
          if ((!phase_r && !rd_r[rem_r[4:0]]) || idx_r + 1'b1 == probes_r) begin
            if (!phase_r && is_add_r) begin
              if (add_cnt_r != '1) add_cnt_nxt = add_cnt_r + 1'b1;
              phase_nxt = 1'b1; idx_nxt = '0; p_nxt = a_r;
              state_nxt = ST_DIV; dv_nxt = a_r; rem_nxt = '0; step_nxt = '0;
            end else begin
              state_nxt = ST_RESP;
            end
          end else begin
            idx_nxt = idx_r + 1'b1; p_nxt = p_r + b_r;
            state_nxt = ST_DIV; dv_nxt = p_r + b_r; rem_nxt = '0; step_nxt = '0;
          end
        end else if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_addr_r <= '0;
      clr_req_r <= 1'b0;
      add_cnt_r <= '0;
      bit_count_r <= BIT_COUNT_RST;
      hash_count_r <= HASH_COUNT_RST;
    end else begin
      state_r <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_req_r <= clr_req_nxt;
      add_cnt_r <= add_cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BIT_COUNT: bit_count_r <= cfg_data;
          default: hash_count_r <= cfg_data[HCOUNT_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hs_r <= hs_nxt; present_r <= present_nxt; is_add_r <= is_add_nxt; phase_r <= phase_nxt;
    pass_r <= pass_nxt; blk_r <= blk_nxt; key_r <= key_nxt; len_r <= len_nxt;
    mod_r <= mod_nxt; probes_r <= probes_nxt; idx_r <= idx_nxt; h_r <= h_nxt; k_r <= k_nxt;
    a_r <= a_nxt; b_r <= b_nxt; p_r <= p_nxt; dv_r <= dv_nxt; rem_r <= rem_nxt;
    step_r <= step_nxt;
  end

  // filter store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_r <= mem[rd_addr];
  end

endmodule
